/* hdl/tplt_pkg.sv */
`default_nettype none

package tplt_pkg;

  // Field and register widths
  localparam int VEL_W     = 32;
  localparam int MU_W      = 16;
  localparam int PT_W      = 48;
  localparam int CFG_IDX_W = 3;
  localparam int SEG_W     = 3;
  localparam int FRC_W     = 32;
  localparam int SLOPE_W   = 48;
  localparam int COEF_W    = 16;

  // Divider and multiplier sizing
  localparam int DEN_W     = 32;
  localparam int NUM_W     = 48;
  localparam int REM_W     = 32;
  localparam int MU_SHIFT  = 26;
  localparam int LIMB_W    = 16;
  localparam int ACC_W     = 79;
  localparam int PROD_W    = ACC_W - LIMB_W;
  localparam int CNT_W     = 6;
  localparam int DIV_STEPS = 48;
  localparam int MUL_STEPS = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_FIRST = 3'd1;

  // Reset and limit values
  localparam logic [CFG_IDX_W-1:0] MIN_POINTS = 3'd2;
  localparam logic [PT_W-1:0]      POINT1_RST = 48'h0001_0000_0000;
  localparam logic [COEF_W-1:0]    COEF_MAX   = 16'hFFFF;
  localparam logic [SLOPE_W-1:0]   SLOPE_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [SLOPE_W-1:0]   SLOPE_MIN  = 48'h8000_0000_0000;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic load_lo;
    logic load_hi;
    logic step_up;
    logic step_dn;
    logic prep;
    logic div_step;
    logic finish;
    logic mul_step;
    logic publish;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic up_more;
    logic dn_start;
    logic dn_more;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/tplt_cfg_regs.sv */
`default_nettype none

module tplt_cfg_regs #(
  parameter int MAX_POINTS = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tplt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tplt_pkg::PT_W-1:0]      cfg_data,
  input  logic [tplt_pkg::SEG_W-1:0]     rd_addr,
  output logic [tplt_pkg::PT_W-1:0]      rd_data,
  output logic [tplt_pkg::SEG_W-1:0]     seg_top
);
  import tplt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] MAX_N = CFG_IDX_W'(MAX_POINTS);

  logic [PT_W-1:0]      point_r [MAX_POINTS];
  logic [CFG_IDX_W-1:0] count_r;
  logic [CFG_IDX_W-1:0] count_use;

  // Write point count and breakpoints; drop writes to unmapped indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= MIN_POINTS;
      for (int i = 0; i < MAX_POINTS; i++) begin
        point_r[i] <= (i == 1) ? POINT1_RST : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_POINT_COUNT) begin
        count_r <= cfg_data[CFG_IDX_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index == REG_POINT_FIRST + CFG_IDX_W'(i)) begin
          point_r[i] <= cfg_data;
        end
      end
    end
  end

  // Clamp point count into the supported range, derive the last segment
  always_comb begin
    if (count_r < MIN_POINTS) begin
      count_use = MIN_POINTS;
    end else if (count_r > MAX_N) begin
      count_use = MAX_N;
    end else begin
      count_use = count_r;
    end
  end

  assign seg_top = count_use - MIN_POINTS;

  // Single read port over the breakpoints
  always_comb begin
    rd_data = '0;
    for (int j = 0; j < MAX_POINTS; j++) begin
      if (SEG_W'(j) == rd_addr) begin
        rd_data = point_r[j];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/tplt_ctrl.sv */
`default_nettype none

module tplt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tplt_pkg::dp_stat_t  stat,
  output tplt_pkg::dp_cmd_t   cmd
);
  import tplt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_LO,
    S_LOAD_HI,
    S_DECIDE,
    S_WALK_UP,
    S_WALK_DN,
    S_PREP,
    S_DIVIDE,
    S_FINISH,
    S_MULT,
    S_PUBLISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one transaction through load, walk, divide and multiply
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOAD_LO;
        end
      end
      S_LOAD_LO: begin
        cmd.load_lo = 1'b1;
        state_nxt   = S_LOAD_HI;
      end
      S_LOAD_HI: begin
        cmd.load_hi = 1'b1;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.up_more) begin
          state_nxt = S_WALK_UP;
        end else if (stat.dn_start) begin
          state_nxt = S_WALK_DN;
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_WALK_UP: begin
        if (stat.up_more) begin
          cmd.step_up = 1'b1;
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_WALK_DN: begin
        if (stat.dn_more) begin
          cmd.step_dn = 1'b1;
        end else begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        cnt_nxt    = CNT_W'(MUL_STEPS - 1);
        state_nxt  = S_MULT;
      end
      S_MULT: begin
        cmd.mul_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_PUBLISH;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_PUBLISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/tplt_dpath.sv */
`default_nettype none

module tplt_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tplt_pkg::dp_cmd_t                 cmd,
  output tplt_pkg::dp_stat_t                stat,
  input  logic signed [tplt_pkg::FRC_W-1:0] in_normal_force,
  input  logic signed [tplt_pkg::VEL_W-1:0] in_velocity,
  input  logic [tplt_pkg::SEG_W-1:0]        seg_top,
  output logic [tplt_pkg::SEG_W-1:0]        rd_addr,
  input  logic [tplt_pkg::PT_W-1:0]         rd_data,
  output logic [tplt_pkg::COEF_W-1:0]       out_coefficient,
  output logic signed [tplt_pkg::SLOPE_W-1:0] out_coefficient_slope,
  output logic signed [tplt_pkg::SLOPE_W-1:0] out_force_slope,
  output logic [tplt_pkg::SEG_W-1:0]        out_segment
);
  import tplt_pkg::*;

  // Segment tracking and bracketing points
  logic [SEG_W-1:0]  idx_r;
  logic [VEL_W-1:0]  a_r, v1_r, v2_r;
  logic [MU_W-1:0]   m1_r, m2_r;
  logic [FRC_W-1:0]  frc_r;

  // Divider state
  logic              dz_r, s1_r, s2_r;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  n1_r, n2_r;
  logic [REM_W-1:0]  r1_r, r2_r;

  // Results and multiplier state
  logic [SLOPE_W-1:0] slope_r;
  logic [COEF_W-1:0]  coef_r;
  logic [NUM_W-1:0]   mq_r;
  logic [ACC_W-1:0]   acc_r;

  // Output registers
  logic [COEF_W-1:0]  oc_r;
  logic [SLOPE_W-1:0] os_r, of_r;
  logic [SEG_W-1:0]   oi_r;

  logic [VEL_W-1:0]  vel_neg, vel_mag;
  logic [SEG_W-1:0]  idx_clamp;
  logic [VEL_W-1:0]  rd_vel;
  logic [MU_W-1:0]   rd_mu;

  // Magnitude of velocity and clamp of a stale segment
  assign vel_neg   = ~in_velocity + VEL_W'(1);
  assign vel_mag   = in_velocity[VEL_W-1] ? vel_neg : in_velocity;
  assign idx_clamp = (idx_r > seg_top) ? seg_top : idx_r;

  // Breakpoint read address for the current command
  always_comb begin
    if (cmd.load_hi) begin
      rd_addr = idx_r + SEG_W'(1);
    end else if (cmd.step_up) begin
      rd_addr = idx_r + SEG_W'(2);
    end else if (cmd.step_dn) begin
      rd_addr = idx_r - SEG_W'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  assign rd_vel = rd_data[PT_W-1:MU_W];
  assign rd_mu  = rd_data[MU_W-1:0];

  // Walk conditions
  assign stat.up_more  = (a_r >= v2_r) && (idx_r < seg_top);
  assign stat.dn_start = (a_r < v1_r) && (idx_r != '0);
  assign stat.dn_more  = (a_r <= v1_r) && (idx_r != '0);

  // Differences, signs and magnitudes for the divide setup
  logic [VEL_W:0]   dv, dx, dv_neg, dx_neg;
  logic [MU_W:0]    dmu, dmu_neg;
  logic [DEN_W-1:0] dv_mag, dx_mag;
  logic [MU_W-1:0]  dmu_mag;
  logic [NUM_W-1:0] prod2;

  assign dv      = {1'b0, v2_r} - {1'b0, v1_r};
  assign dx      = {1'b0, a_r} - {1'b0, v1_r};
  assign dmu     = {1'b0, m2_r} - {1'b0, m1_r};
  assign dv_neg  = -dv;
  assign dx_neg  = -dx;
  assign dmu_neg = -dmu;
  assign dv_mag  = dv[VEL_W] ? dv_neg[DEN_W-1:0] : dv[DEN_W-1:0];
  assign dx_mag  = dx[VEL_W] ? dx_neg[DEN_W-1:0] : dx[DEN_W-1:0];
  assign dmu_mag = dmu[MU_W] ? dmu_neg[MU_W-1:0] : dmu[MU_W-1:0];
  assign prod2   = NUM_W'(dmu_mag) * NUM_W'(dx_mag);

  // One restoring step for each of the two quotients
  logic [REM_W:0]   t1, t2;
  logic             ge1, ge2;
  logic [REM_W:0]   d1, d2;

  assign t1  = {r1_r, n1_r[NUM_W-1]};
  assign t2  = {r2_r, n2_r[NUM_W-1]};
  assign ge1 = t1 >= {1'b0, den_r};
  assign ge2 = t2 >= {1'b0, den_r};
  assign d1  = t1 - {1'b0, den_r};
  assign d2  = t2 - {1'b0, den_r};

  // Apply signs, saturate the coefficient
  logic [SLOPE_W-1:0] slope_val;
  logic [NUM_W:0]     c_sum;
  logic [COEF_W-1:0]  coef_val;

  assign c_sum = {1'b0, n2_r} + (NUM_W + 1)'(m1_r);

  always_comb begin
    if (dz_r) begin
      slope_val = '0;
      coef_val  = m1_r;
    end else begin
      slope_val = s1_r ? -n1_r : n1_r;
      if (s2_r) begin
        coef_val = (n2_r > NUM_W'(m1_r)) ? '0 : (m1_r - n2_r[COEF_W-1:0]);
      end else begin
        coef_val = (c_sum > (NUM_W + 1)'(COEF_MAX)) ? COEF_MAX : c_sum[COEF_W-1:0];
      end
    end
  end

  // One limb of slope magnitude times force per step
  logic [LIMB_W+FRC_W-2:0] pp;

  assign pp = (LIMB_W + FRC_W - 1)'(mq_r[NUM_W-1 -: LIMB_W])
            * (LIMB_W + FRC_W - 1)'(frc_r[FRC_W-2:0]);

  // Drop the force fraction and saturate the force slope
  logic [PROD_W-1:0]  p_mag;
  logic               f_pos;
  logic [SLOPE_W-1:0] fs_val;

  assign p_mag = acc_r[ACC_W-1:LIMB_W];
  assign f_pos = !frc_r[FRC_W-1] && (frc_r != '0);

  always_comb begin
    if (!f_pos) begin
      fs_val = '0;
    end else if (!slope_r[SLOPE_W-1]) begin
      fs_val = (p_mag > PROD_W'(SLOPE_MAX)) ? SLOPE_MAX : p_mag[SLOPE_W-1:0];
    end else begin
      fs_val = (p_mag > PROD_W'(SLOPE_MIN)) ? SLOPE_MIN : -p_mag[SLOPE_W-1:0];
    end
  end

  // Tracked segment index survives between transactions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.capture) begin
      idx_r <= idx_clamp;
    end else if (cmd.step_up) begin
      idx_r <= idx_r + SEG_W'(1);
    end else if (cmd.step_dn) begin
      idx_r <= idx_r - SEG_W'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_r   <= vel_mag;
      frc_r <= in_normal_force;
    end
    if (cmd.load_lo) begin
      v1_r <= rd_vel;
      m1_r <= rd_mu;
    end
    if (cmd.load_hi) begin
      v2_r <= rd_vel;
      m2_r <= rd_mu;
    end
    if (cmd.step_up) begin
      v1_r <= v2_r;
      m1_r <= m2_r;
      v2_r <= rd_vel;
      m2_r <= rd_mu;
    end
    if (cmd.step_dn) begin
      v2_r <= v1_r;
      m2_r <= m1_r;
      v1_r <= rd_vel;
      m1_r <= rd_mu;
    end
    if (cmd.prep) begin
      dz_r  <= (dv == '0);
      s1_r  <= dmu[MU_W] ^ dv[VEL_W];
      s2_r  <= dmu[MU_W] ^ dv[VEL_W] ^ dx[VEL_W];
      den_r <= dv_mag;
      n1_r  <= NUM_W'({dmu_mag, {MU_SHIFT{1'b0}}});
      n2_r  <= prod2;
      r1_r  <= '0;
      r2_r  <= '0;
    end
    if (cmd.div_step) begin
      r1_r <= ge1 ? d1[REM_W-1:0] : t1[REM_W-1:0];
      r2_r <= ge2 ? d2[REM_W-1:0] : t2[REM_W-1:0];
      n1_r <= {n1_r[NUM_W-2:0], ge1};
      n2_r <= {n2_r[NUM_W-2:0], ge2};
    end
    if (cmd.finish) begin
      slope_r <= slope_val;
      coef_r  <= coef_val;
      mq_r    <= dz_r ? '0 : n1_r;
      acc_r   <= '0;
    end
    if (cmd.mul_step) begin
      acc_r <= {acc_r[ACC_W-LIMB_W-1:0], {LIMB_W{1'b0}}} + ACC_W'(pp);
      mq_r  <= {mq_r[NUM_W-LIMB_W-1:0], {LIMB_W{1'b0}}};
    end
    if (cmd.publish) begin
      oc_r <= coef_r;
      os_r <= slope_r;
      of_r <= fs_val;
      oi_r <= idx_r;
    end
  end

  assign out_coefficient       = oc_r;
  assign out_coefficient_slope = os_r;
  assign out_force_slope       = of_r;
  assign out_segment           = oi_r;

endmodule

`default_nettype wire

/* hdl/tracked_piecewise_linear_lookup_top.sv */
// Each transaction loads the bracketing points, then walks the segment index (at
//   most 5 steps) or skips the walk when neither walk condition holds.
// A new input is taken only once the 48-step restoring divider and the three-limb
//   force multiply of the one shared datapath are done and the result is published.
// A finished result waits in the output register while the next input is taken.
// Reset: synchronous, active low; clears control and segment index, loads config defaults.
`default_nettype none

module tracked_piecewise_linear_lookup_top #(
  parameter int MAX_POINTS = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tplt_pkg::FRC_W-1:0]   in_normal_force,
  input  logic signed [tplt_pkg::VEL_W-1:0]   in_velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tplt_pkg::COEF_W-1:0]         out_coefficient,
  output logic signed [tplt_pkg::SLOPE_W-1:0] out_coefficient_slope,
  output logic signed [tplt_pkg::SLOPE_W-1:0] out_force_slope,
  output logic [tplt_pkg::SEG_W-1:0]          out_segment,
  input  logic                                cfg_we,
  input  logic [tplt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tplt_pkg::PT_W-1:0]           cfg_data
);
  import tplt_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [SEG_W-1:0] rd_addr;
  logic [PT_W-1:0]  rd_data;
  logic [SEG_W-1:0] seg_top;

  tplt_cfg_regs #(
    .MAX_POINTS (MAX_POINTS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .seg_top   (seg_top)
  );

  tplt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tplt_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_normal_force       (in_normal_force),
    .in_velocity           (in_velocity),
    .seg_top               (seg_top),
    .rd_addr               (rd_addr),
    .rd_data               (rd_data),
    .out_coefficient       (out_coefficient),
    .out_coefficient_slope (out_coefficient_slope),
    .out_force_slope       (out_force_slope),
    .out_segment           (out_segment)
  );

endmodule

`default_nettype wire

/* hdl/tplt_checker.sv */
`default_nettype none

module tplt_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [tplt_pkg::COEF_W-1:0]         out_coefficient,
  input  logic signed [tplt_pkg::SLOPE_W-1:0] out_coefficient_slope,
  input  logic signed [tplt_pkg::SLOPE_W-1:0] out_force_slope,
  input  logic [tplt_pkg::SEG_W-1:0]          out_segment
);
  import tplt_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coefficient)
      && $stable(out_coefficient_slope) && $stable(out_force_slope)
      && $stable(out_segment))
    else $error("stalled result changed");

  // Block is busy right after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // Zero slope gives zero force slope
  a_zero_slope: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_coefficient_slope == '0) |-> (out_force_slope == '0))
    else $error("force slope without slope");

  // Force slope carries the sign of the slope
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_force_slope != '0)
      |-> (out_force_slope[SLOPE_W-1] == out_coefficient_slope[SLOPE_W-1]))
    else $error("force slope sign mismatch");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tracked_piecewise_linear_lookup_top tplt_checker u_tplt_checker (.*);

`default_nettype wire
